// ===== rtl/core/spch_pkg.sv =====
// Shared types and constants for the segment / convex polygon closest-hit block.
// No dependencies; imported by spch_front, spch_back and segment_polygon_closest_hit.
package spch_pkg;

  localparam int FRAC_W    = 16;
  localparam int ID_W      = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STEPS = FRAC_W;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_A_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_B_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_B_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP = 3'd6;

  // result word layout, lowest bit first; normals and halted follow OFS_NNORM
  localparam int OFS_HIT   = 0;
  localparam int OFS_PFRAC = 1;
  localparam int OFS_ANY   = OFS_PFRAC + FRAC_W;
  localparam int OFS_NFRAC = OFS_ANY + 1;
  localparam int OFS_NPOLY = OFS_NFRAC + FRAC_W;
  localparam int OFS_NNORM = OFS_NPOLY + ID_W;

  // steps of one edge test, per cross product component
  localparam logic [1:0] EOP_CROSS_P = 2'd0;
  localparam logic [1:0] EOP_CROSS_M = 2'd1;
  localparam logic [1:0] EOP_DOT_LO  = 2'd2;
  localparam logic [1:0] EOP_DOT_HI  = 2'd3;

  typedef struct packed {
    logic starts_query;
    logic first_vertex;
    logic last_vertex;
  } vtx_flags_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DOT,
    ST_CHECK,
    ST_DIV,
    ST_PT,
    ST_EDGE,
    ST_AFTER,
    ST_RESULT
  } state_t;

endpackage

// ===== rtl/core/spch_front.sv =====
// Front end: two-word vertex queue that takes stream words and splits them into fields.
// Depends on spch_pkg for the vertex flag struct.
module spch_front #(
  parameter int CW = 32,
  parameter int NW = 16,
  localparam int PL_W = 3 * CW + 3 * NW + spch_pkg::ID_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  spch_pkg::vtx_flags_t   in_flags,
  input  logic [PL_W-1:0]        in_data,
  output logic                   q_valid,
  input  logic                   q_pop,
  output spch_pkg::vtx_flags_t   q_flags,
  output logic signed [CW-1:0]   q_vtx [3],
  output logic signed [NW-1:0]   q_norm [3],
  output logic [spch_pkg::ID_W-1:0] q_poly
);
  import spch_pkg::*;

  vtx_flags_t      flags_mem_r [2];
  logic [PL_W-1:0] data_mem_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r;
  logic            push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      flags_mem_r[wr_ptr_r] <= in_flags;
      data_mem_r[wr_ptr_r]  <= in_data;
    end
  end

  always_comb begin
    q_flags = flags_mem_r[rd_ptr_r];
    for (int k = 0; k < 3; k++) begin
      q_vtx[k]  = $signed(data_mem_r[rd_ptr_r][k*CW +: CW]);
      q_norm[k] = $signed(data_mem_r[rd_ptr_r][3*CW + k*NW +: NW]);
    end
    q_poly = data_mem_r[rd_ptr_r][3*CW + 3*NW +: ID_W];
  end

endmodule

// ===== rtl/core/spch_back.sv =====
// Back end: sequencer with one shared multiplier, a restoring divider and the hit tracker.
// Depends on spch_pkg for states, step codes and the result word layout.
module spch_back #(
  parameter int CW = 32,
  parameter int NW = 16,
  localparam int OUT_W = ((3 + 2 * spch_pkg::FRAC_W + spch_pkg::ID_W + 3 * NW + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic signed [CW-1:0]   seg_a [3],
  input  logic signed [CW-1:0]   seg_b [3],
  input  logic                   stop_first,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  spch_pkg::vtx_flags_t   q_flags,
  input  logic signed [CW-1:0]   q_vtx [3],
  input  logic signed [NW-1:0]   q_norm [3],
  input  logic [spch_pkg::ID_W-1:0] q_poly,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_W-1:0]       out_data
);
  import spch_pkg::*;

  localparam int MW     = (CW + 2 > NW) ? CW + 2 : NW;
  localparam int PW     = 2 * MW;
  localparam int LW     = CW + 1;
  localparam int CXW    = 2 * CW + 3;
  localparam int SW     = 2 * CW + NW + 5;
  localparam int DIV_CW = $clog2(DIV_STEPS);
  localparam int OFS_HALT = OFS_NNORM + 3 * NW;

  state_t state_r, state_nxt;

  logic signed [CW-1:0] v_r [3], first_r [3], prev_r [3], pt_r [3];
  logic signed [NW-1:0] nin_r [3], norm_r [3], hnorm_r [3];
  vtx_flags_t           flags_r;
  logic [ID_W-1:0]      poly_r, hpoly_r;
  logic signed [CW:0]   t_r [3], e_r [3];
  logic signed [PW-1:0] p_r;
  logic signed [CXW-1:0] cacc_r;
  logic signed [SW-1:0] sacc_r, da_r, den_r, rem_r;
  logic [FRAC_W:0]      r17_r;
  logic [FRAC_W-1:0]    frac_r, hfrac_r;
  logic                 cand_r, hit_r, close_r, hheld_r, frozen_r, phase_r;
  logic [1:0]           comp_r, sub_r;
  logic [DIV_CW-1:0]    div_cnt_r;
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_data_r;

  // sequencer strobes
  logic op_last, op_done, res_fire;

  // datapath
  logic [1:0]           ci, cj;
  logic signed [CW:0]   dav, dvb, dba;
  logic signed [MW-1:0] opa, opb;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] p_s, acc_sum;
  logic signed [CXW-1:0] p_c;
  logic                 edge_ok;
  logic signed [SW-1:0] chk_den, div_rem2, div_rem_nxt;
  logic                 chk_cand, chk_full, div_bit;
  logic                 upd, hh_n, frz_n;
  logic [FRAC_W-1:0]    hf_n, frac_sat;
  logic [ID_W-1:0]      hp_n;
  logic [OUT_W-1:0]     res_data;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- sequencer ----------------
  always_comb begin
    q_pop    = (state_r == ST_IDLE) && q_valid;
    res_fire = (state_r == ST_RESULT) && (!out_valid_r || out_ready);
    case (state_r)
      ST_DOT:  op_last = (sub_r == 2'd1) && (comp_r == 2'd2);
      ST_EDGE: op_last = (sub_r == EOP_DOT_HI) && (comp_r == 2'd2);
      ST_PT:   op_last = (comp_r == 2'd2);
      default: op_last = 1'b0;
    endcase
    op_done = phase_r && op_last;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) state_nxt = ST_START;
      end
      ST_START: begin
        if (frozen_r) begin
          state_nxt = flags_r.last_vertex ? ST_RESULT : ST_IDLE;
        end else if (flags_r.first_vertex) begin
          state_nxt = ST_DOT;
        end else if (cand_r) begin
          state_nxt = ST_EDGE;
        end else begin
          state_nxt = ST_AFTER;
        end
      end
      ST_DOT: begin
        if (op_done) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!chk_cand) begin
          state_nxt = ST_AFTER;
        end else if (chk_full) begin
          state_nxt = ST_PT;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_r == DIV_CW'(DIV_STEPS - 1)) state_nxt = ST_PT;
      end
      ST_PT: begin
        if (op_done) state_nxt = ST_AFTER;
      end
      ST_EDGE: begin
        if (op_done) state_nxt = close_r ? ST_RESULT : ST_AFTER;
      end
      ST_AFTER: begin
        if (!flags_r.last_vertex) begin
          state_nxt = ST_IDLE;
        end else if (cand_r) begin
          state_nxt = ST_EDGE;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- multiplier operands ----------------
  always_comb begin
    case (comp_r)
      2'd0:    begin ci = 2'd1; cj = 2'd2; end
      2'd1:    begin ci = 2'd2; cj = 2'd0; end
      default: begin ci = 2'd0; cj = 2'd1; end
    endcase
    dav = (CW+1)'(seg_a[comp_r]) - (CW+1)'(v_r[comp_r]);
    dvb = (CW+1)'(v_r[comp_r]) - (CW+1)'(seg_b[comp_r]);
    dba = (CW+1)'(seg_b[comp_r]) - (CW+1)'(seg_a[comp_r]);
    opa = '0;
    opb = '0;
    case (state_r)
      ST_DOT: begin
        opa = (sub_r == 2'd0) ? MW'(dav) : MW'(dvb);
        opb = MW'(norm_r[comp_r]);
      end
      ST_PT: begin
        opa = MW'(dba);
        opb = MW'({1'b0, r17_r});
      end
      ST_EDGE: begin
        case (sub_r)
          EOP_CROSS_P: begin
            opa = MW'(t_r[ci]);
            opb = MW'(e_r[cj]);
          end
          EOP_CROSS_M: begin
            opa = MW'(t_r[cj]);
            opb = MW'(e_r[ci]);
          end
          EOP_DOT_LO: begin
            opa = MW'({1'b0, cacc_r[LW-1:0]});
            opb = MW'(norm_r[comp_r]);
          end
          default: begin
            opa = MW'($signed(cacc_r[CXW-1:LW]));
            opb = MW'(norm_r[comp_r]);
          end
        endcase
      end
      default: ;
    endcase
  end

  assign prod = opa * opb;

  // ---------------- accumulate, check, divide ----------------
  always_comb begin
    p_s = SW'(p_r);
    p_c = $signed(p_r[CXW-1:0]);
    if (state_r == ST_EDGE && sub_r == EOP_DOT_HI) begin
      acc_sum = sacc_r + (p_s <<< LW);
    end else begin
      acc_sum = sacc_r + p_s;
    end
    edge_ok = !acc_sum[SW-1];

    chk_den  = da_r + sacc_r;
    chk_cand = !da_r[SW-1] && !sacc_r[SW-1] && (chk_den != '0);
    chk_full = (da_r >= chk_den);

    div_rem2    = rem_r <<< 1;
    div_bit     = (div_rem2 >= den_r);
    div_rem_nxt = div_bit ? div_rem2 - den_r : div_rem2;

    frac_sat = r17_r[FRAC_W] ? {FRAC_W{1'b1}} : r17_r[FRAC_W-1:0];
  end

  // ---------------- nearest-hit update and result word ----------------
  always_comb begin
    upd   = hit_r && (!hheld_r || frac_r <= hfrac_r);
    hh_n  = hheld_r || upd;
    hf_n  = upd ? frac_r : hfrac_r;
    hp_n  = upd ? poly_r : hpoly_r;
    frz_n = frozen_r || (hh_n && stop_first);
    res_data = '0;
    res_data[OFS_HIT] = hit_r;
    res_data[OFS_PFRAC +: FRAC_W] = hit_r ? frac_r : '0;
    res_data[OFS_ANY] = hh_n;
    res_data[OFS_NFRAC +: FRAC_W] = hf_n;
    res_data[OFS_NPOLY +: ID_W] = hp_n;
    for (int k = 0; k < 3; k++) begin
      res_data[OFS_NNORM + k*NW +: NW] = upd ? norm_r[k] : hnorm_r[k];
    end
    res_data[OFS_HALT] = frz_n;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      comp_r      <= 2'd0;
      sub_r       <= 2'd0;
      div_cnt_r   <= '0;
      cand_r      <= 1'b0;
      hit_r       <= 1'b0;
      close_r     <= 1'b0;
      hheld_r     <= 1'b0;
      hfrac_r     <= '0;
      hpoly_r     <= '0;
      frozen_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) hnorm_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (q_valid && q_flags.starts_query) begin
            hheld_r  <= 1'b0;
            hfrac_r  <= '0;
            hpoly_r  <= '0;
            frozen_r <= 1'b0;
            for (int k = 0; k < 3; k++) hnorm_r[k] <= '0;
          end
        end
        ST_START: begin
          phase_r <= 1'b0;
          comp_r  <= 2'd0;
          sub_r   <= 2'd0;
          close_r <= 1'b0;
          hit_r   <= 1'b0;
        end
        ST_DOT, ST_EDGE, ST_PT: begin
          phase_r <= ~phase_r;
          if (op_done) begin
            comp_r <= 2'd0;
            sub_r  <= 2'd0;
            if (state_r == ST_EDGE) begin
              if (close_r) begin
                hit_r <= cand_r && edge_ok;
              end else if (!edge_ok) begin
                cand_r <= 1'b0;
              end
            end
          end else if (phase_r) begin
            if (state_r == ST_EDGE) begin
              if (sub_r == EOP_DOT_HI) begin
                sub_r  <= 2'd0;
                comp_r <= comp_r + 2'd1;
              end else begin
                sub_r <= sub_r + 2'd1;
              end
            end else if (comp_r == 2'd2) begin
              comp_r <= 2'd0;
              sub_r  <= sub_r + 2'd1;
            end else begin
              comp_r <= comp_r + 2'd1;
            end
          end
        end
        ST_CHECK: begin
          cand_r    <= chk_cand;
          div_cnt_r <= '0;
        end
        ST_DIV: begin
          div_cnt_r <= div_cnt_r + DIV_CW'(1);
        end
        ST_AFTER: begin
          if (flags_r.last_vertex) begin
            if (cand_r) begin
              close_r <= 1'b1;
            end else begin
              hit_r <= 1'b0;
            end
          end
        end
        ST_RESULT: begin
          if (res_fire) begin
            hheld_r  <= hh_n;
            hfrac_r  <= hf_n;
            hpoly_r  <= hp_n;
            frozen_r <= frz_n;
            cand_r   <= 1'b0;
            if (upd) begin
              for (int k = 0; k < 3; k++) hnorm_r[k] <= norm_r[k];
            end
          end
        end
        default: ;
      endcase
      if (res_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (q_pop) begin
      flags_r <= q_flags;
      poly_r  <= q_poly;
      for (int k = 0; k < 3; k++) begin
        v_r[k]   <= q_vtx[k];
        nin_r[k] <= q_norm[k];
      end
    end
    if (res_fire) out_data_r <= res_data;
    case (state_r)
      ST_START: begin
        if (!frozen_r) begin
          sacc_r <= '0;
          for (int k = 0; k < 3; k++) begin
            prev_r[k] <= v_r[k];
            if (flags_r.first_vertex) begin
              norm_r[k]  <= nin_r[k];
              first_r[k] <= v_r[k];
            end else begin
              t_r[k] <= (CW+1)'(pt_r[k]) - (CW+1)'(prev_r[k]);
              e_r[k] <= (CW+1)'(v_r[k]) - (CW+1)'(prev_r[k]);
            end
          end
        end
      end
      ST_DOT: begin
        if (!phase_r) begin
          p_r <= prod;
        end else if (sub_r == 2'd0 && comp_r == 2'd2) begin
          // da complete; start db from zero
          da_r   <= acc_sum;
          sacc_r <= '0;
        end else begin
          sacc_r <= acc_sum;
        end
      end
      ST_CHECK: begin
        frac_r <= '0;
        den_r  <= chk_den;
        rem_r  <= da_r;
        r17_r  <= chk_full ? {1'b1, {FRAC_W{1'b0}}} : '0;
      end
      ST_DIV: begin
        rem_r <= div_rem_nxt;
        r17_r <= {r17_r[FRAC_W-1:0], div_bit};
      end
      ST_PT: begin
        if (!phase_r) begin
          p_r <= prod;
        end else begin
          pt_r[comp_r] <= CW'(PW'(seg_a[comp_r]) + (p_r >>> FRAC_W));
          if (op_last) frac_r <= frac_sat;
        end
      end
      ST_EDGE: begin
        if (!phase_r) begin
          p_r <= prod;
        end else begin
          case (sub_r)
            EOP_CROSS_P: cacc_r <= p_c;
            EOP_CROSS_M: cacc_r <= cacc_r - p_c;
            default:     sacc_r <= acc_sum;
          endcase
        end
      end
      ST_AFTER: begin
        // closing edge runs from this vertex back to the first one
        if (flags_r.last_vertex && cand_r) begin
          sacc_r <= '0;
          for (int k = 0; k < 3; k++) begin
            t_r[k] <= (CW+1)'(pt_r[k]) - (CW+1)'(v_r[k]);
            e_r[k] <= (CW+1)'(first_r[k]) - (CW+1)'(v_r[k]);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/segment_polygon_closest_hit.sv =====
// Top level: configuration registers, vertex queue (spch_front) and engine (spch_back).
// Depends on spch_pkg, spch_front and spch_back.
//
//   channel  dir  handshake               payload
//   cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//   in_      in   in_tvalid / in_tready   in_tdata, in_tuser, in_tlast
//   out_     out  out_tvalid / out_tready out_tdata
//
// One shared multiplier runs each product as a multiply phase, then an accumulate phase.
// Opening vertex: 6 dot products, then, for a candidate, a 16-step divide (skipped at
// saturation) and 3 point products. Other vertex: a 12-product edge test while still a
// candidate; a closing vertex adds the closing edge and the result. Synchronous
// active-low reset clears the held hit; the queue holds two words, so input stalls only
// when both are queued, and the engine stalls only while the previous result waits.
module segment_polygon_closest_hit #(
  parameter int COORD_WIDTH  = 32,
  parameter int NORMAL_WIDTH = 16,
  localparam int IN_RAW = 3 * COORD_WIDTH + 3 * NORMAL_WIDTH + spch_pkg::ID_W,
  localparam int IN_W   = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_W  =
    ((3 + 2 * spch_pkg::FRAC_W + spch_pkg::ID_W + 3 * NORMAL_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [spch_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]         cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z, polygon_id, zero fill
  input  logic [IN_W-1:0]                in_tdata,
  // starts_query, first_vertex
  input  logic [1:0]                     in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // polygon_hit, polygon_fraction, any_hit, nearest_fraction, nearest_polygon,
  // nearest_normal_x, nearest_normal_y, nearest_normal_z, halted, zero fill
  output logic [OUT_W-1:0]               out_tdata
);
  import spch_pkg::*;

  localparam int OFS_HALT = OFS_NNORM + 3 * NORMAL_WIDTH;

  logic signed [COORD_WIDTH-1:0]  seg_a_r [3], seg_b_r [3];
  logic                           stop_r;
  vtx_flags_t                     in_flags, q_flags;
  logic                           q_valid, q_pop;
  logic signed [COORD_WIDTH-1:0]  q_vtx [3];
  logic signed [NORMAL_WIDTH-1:0] q_norm [3];
  logic [ID_W-1:0]                q_poly;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        seg_a_r[k] <= '0;
        seg_b_r[k] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_A_X:  seg_a_r[0] <= $signed(cfg_data);
        CFG_A_Y:  seg_a_r[1] <= $signed(cfg_data);
        CFG_A_Z:  seg_a_r[2] <= $signed(cfg_data);
        CFG_B_X:  seg_b_r[0] <= $signed(cfg_data);
        CFG_B_Y:  seg_b_r[1] <= $signed(cfg_data);
        CFG_B_Z:  seg_b_r[2] <= $signed(cfg_data);
        CFG_STOP: stop_r <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    in_flags.starts_query = in_tuser[0];
    in_flags.first_vertex = in_tuser[1];
    in_flags.last_vertex  = in_tlast;
  end

  spch_front #(
    .CW (COORD_WIDTH),
    .NW (NORMAL_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_flags (in_flags),
    .in_data  (in_tdata[IN_RAW-1:0]),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_flags  (q_flags),
    .q_vtx    (q_vtx),
    .q_norm   (q_norm),
    .q_poly   (q_poly)
  );

  spch_back #(
    .CW (COORD_WIDTH),
    .NW (NORMAL_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .seg_a      (seg_a_r),
    .seg_b      (seg_b_r),
    .stop_first (stop_r),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_flags    (q_flags),
    .q_vtx      (q_vtx),
    .q_norm     (q_norm),
    .q_poly     (q_poly),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

`ifndef SYNTHESIS
  a_nearest_not_farther: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OFS_HIT] |->
      out_tdata[OFS_NFRAC +: FRAC_W] <= out_tdata[OFS_PFRAC +: FRAC_W])
    else $error("nearest fraction exceeds the fraction of a hit polygon");

  a_halt_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OFS_HALT] |-> out_tdata[OFS_ANY])
    else $error("query halted without a held hit");

  a_push_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> q_valid)
    else $error("accepted vertex word missing from the queue");
`endif

endmodule

// ===== tb/segment_polygon_closest_hit_test.sv =====
// Testbench for segment_polygon_closest_hit: drives polygons as vertex words, predicts
// every result word with exact wide arithmetic, and compares field by field.
// Depends on spch_pkg and the segment_polygon_closest_hit RTL.
module segment_polygon_closest_hit_test;
  import spch_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    bit                 sq, fv, lv;
    logic signed [31:0] x, y, z;
    logic signed [15:0] nx, ny, nz;
    logic        [15:0] id;
  } vertex_t;

  typedef struct {
    bit                 hit;
    logic        [15:0] pfrac;
    bit                 any;
    logic        [15:0] nfrac;
    logic        [15:0] npoly;
    logic signed [15:0] nx, ny, nz;
    bit                 halted;
  } hit_report_t;

  logic         clk, rst_n;
  logic         cfg_valid, cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         in_tvalid, in_tready, in_tlast;
  logic [159:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid, out_tready;
  logic [103:0] out_tdata;

  segment_polygon_closest_hit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // predictor state
  longint      seg_pt[6];
  bit          stop_first;
  longint      first_c[3], prev_c[3], xpt[3], fnorm[3], held_norm[3];
  logic [15:0] cur_frac, held_frac, held_poly;
  bit          cand, held, frozen;

  hit_report_t pending_hits[$];
  int          mismatches;
  int          burst_left;
  bit          idle_on;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  function automatic bit edge_pass(input longint p[3], input longint q[3]);
    longint t[3], e[3];
    wide_t  c0, c1, c2, s;
    for (int k = 0; k < 3; k++) begin
      t[k] = xpt[k] - p[k];
      e[k] = q[k] - p[k];
    end
    c0 = wide_t'(t[1]) * wide_t'(e[2]) - wide_t'(t[2]) * wide_t'(e[1]);
    c1 = wide_t'(t[2]) * wide_t'(e[0]) - wide_t'(t[0]) * wide_t'(e[2]);
    c2 = wide_t'(t[0]) * wide_t'(e[1]) - wide_t'(t[1]) * wide_t'(e[0]);
    s = c0 * wide_t'(fnorm[0]) + c1 * wide_t'(fnorm[1]) + c2 * wide_t'(fnorm[2]);
    return s >= 0;
  endfunction

  function automatic void open_face(input longint v[3]);
    wide_t  da, db, den, r17;
    da = '0;
    db = '0;
    for (int k = 0; k < 3; k++) begin
      da += wide_t'(seg_pt[k] - v[k]) * wide_t'(fnorm[k]);
      db += wide_t'(v[k] - seg_pt[3+k]) * wide_t'(fnorm[k]);
    end
    den = da + db;
    cand = (da >= 0) && (db >= 0) && (den != 0);
    cur_frac = '0;
    for (int k = 0; k < 3; k++) xpt[k] = 0;
    if (!cand) return;
    r17 = (da >= den) ? wide_t'(65536) : (da <<< 16) / den;
    cur_frac = (r17 > 65535) ? 16'hFFFF : r17[15:0];
    for (int k = 0; k < 3; k++)
      xpt[k] = seg_pt[k] + longint'((wide_t'(seg_pt[3+k] - seg_pt[k]) * r17) >>> 16);
  endfunction

  function automatic void predict_vertex(input vertex_t w);
    longint      v[3];
    bit          hit;
    hit_report_t r;
    hit = 0;
    if (w.sq) begin
      held = 0; held_frac = '0; held_poly = '0; frozen = 0;
      for (int k = 0; k < 3; k++) held_norm[k] = 0;
    end
    v[0] = longint'(w.x); v[1] = longint'(w.y); v[2] = longint'(w.z);
    if (!frozen) begin
      if (w.fv) begin
        fnorm[0] = longint'(w.nx); fnorm[1] = longint'(w.ny); fnorm[2] = longint'(w.nz);
        first_c = v;
        open_face(v);
      end else if (cand && !edge_pass(prev_c, v)) begin
        cand = 0;
      end
      prev_c = v;
    end
    if (!w.lv) return;
    if (!frozen) begin
      hit = cand && edge_pass(v, first_c);
      if (hit && (!held || cur_frac <= held_frac)) begin
        held = 1; held_frac = cur_frac; held_poly = w.id;
        held_norm = fnorm;
      end
      if (held && stop_first) frozen = 1;
    end
    cand = 0;
    r.hit = hit; r.pfrac = hit ? cur_frac : 16'd0;
    r.any = held; r.nfrac = held_frac; r.npoly = held_poly;
    r.nx = 16'(held_norm[0]); r.ny = 16'(held_norm[1]); r.nz = 16'(held_norm[2]);
    r.halted = frozen;
    pending_hits.push_back(r);
  endfunction

  // receiver: alternate between free-running, random stalls and long stalls
  int stall_phase;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case ((stall_phase >> 9) % 3)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      hit_report_t w;
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected word", out_tdata[63:0], 0);
      end else begin
        w = pending_hits.pop_front();
        if (out_tdata[OFS_HIT] !== w.hit) report_mismatch("polygon_hit", out_tdata[OFS_HIT], w.hit);
        if (out_tdata[16:1] !== w.pfrac) report_mismatch("polygon_fraction", out_tdata[16:1], w.pfrac);
        if (out_tdata[17] !== w.any) report_mismatch("any_hit", out_tdata[17], w.any);
        if (out_tdata[33:18] !== w.nfrac) report_mismatch("nearest_fraction", out_tdata[33:18], w.nfrac);
        if (out_tdata[49:34] !== w.npoly) report_mismatch("nearest_polygon", out_tdata[49:34], w.npoly);
        if (out_tdata[65:50] !== w.nx) report_mismatch("nearest_normal_x", out_tdata[65:50], w.nx);
        if (out_tdata[81:66] !== w.ny) report_mismatch("nearest_normal_y", out_tdata[81:66], w.ny);
        if (out_tdata[97:82] !== w.nz) report_mismatch("nearest_normal_z", out_tdata[97:82], w.nz);
        if (out_tdata[98] !== w.halted) report_mismatch("halted", out_tdata[98], w.halted);
      end
    end
  end

  task automatic send_vertex(input vertex_t w);
    int gap;
    if (idle_on && burst_left == 0) begin
      gap = $urandom_range(0, 30);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {w.id, w.nz, w.ny, w.nx, w.z, w.y, w.x};
    in_tuser  <= {w.fv, w.sq};
    in_tlast  <= w.lv;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_vertex(w);
  endtask

  // hold the sender until every result is back, then let the engine settle
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_STOP) stop_first = value[0];
    else seg_pt[idx] = longint'(signed'(value));
    @(posedge clk);
  endtask

  task automatic set_segment(input longint ax, ay, az, bx, by, bz, input bit stop);
    write_reg(CFG_A_X, ax[31:0]);
    write_reg(CFG_A_Y, ay[31:0]);
    write_reg(CFG_A_Z, az[31:0]);
    write_reg(CFG_B_X, bx[31:0]);
    write_reg(CFG_B_Y, by[31:0]);
    write_reg(CFG_B_Z, bz[31:0]);
    write_reg(CFG_STOP, {31'd0, stop});
  endtask

  // square-ish polygon in a plane z = pz, corners walked clockwise seen from +z
  task automatic send_polygon(input bit sq, input int corners, input longint cx, cy, pz,
                              input longint r, input logic signed [15:0] nx, ny, nz,
                              input logic [15:0] id, input int jitter);
    vertex_t w;
    longint  sx[4] = '{1, 1, -1, -1};
    longint  sy[4] = '{1, -1, -1, 1};
    for (int i = 0; i < corners; i++) begin
      w.sq = sq && (i == 0);
      w.fv = (i == 0);
      w.lv = (i == corners - 1);
      w.x  = 32'(cx + sx[i % 4] * r + $urandom_range(0, jitter));
      w.y  = 32'(cy + sy[i % 4] * r + $urandom_range(0, jitter));
      w.z  = 32'(pz);
      w.nx = nx; w.ny = ny; w.nz = nz;
      w.id = id;
      send_vertex(w);
    end
  endtask

  function automatic vertex_t noise_vertex();
    vertex_t w;
    w.sq = $urandom_range(0, 7) == 0;
    w.fv = $urandom_range(0, 1) == 1;
    w.lv = $urandom_range(0, 1) == 1;
    w.x = $urandom; w.y = $urandom; w.z = $urandom;
    w.nx = 16'($urandom); w.ny = 16'($urandom); w.nz = 16'($urandom);
    w.id = 16'($urandom);
    return w;
  endfunction

  task automatic test_basic_crossings;
    vertex_t w;
    set_segment(0, 0, 10 <<< 16, 0, 0, -(10 <<< 16), 0);
    send_polygon(1, 4, 0, 0, 0, 3 <<< 16, 0, 0, 32767, 16'd1, 0);
    send_polygon(0, 4, 0, 0, -(5 <<< 16), 3 <<< 16, 0, 0, 32767, 16'd2, 0);
    // equal fraction takes over the held hit
    send_polygon(0, 3, 0, 0, 0, 2 <<< 16, 100, -100, 32767, 16'd3, 0);
    // B on the plane: fraction saturates
    send_polygon(0, 4, 0, 0, -(10 <<< 16), 1 <<< 16, 0, 0, 32767, 16'd4, 0);
    // zero normal gives a zero denominator
    send_polygon(0, 4, 0, 0, 0, 1 <<< 16, 0, 0, 0, 16'd5, 0);
    // single-vertex polygon
    send_polygon(1, 1, 0, 0, 2 <<< 16, 0, 0, 0, 32767, 16'd6, 0);
    // vertex with no open polygon
    w = '{sq: 0, fv: 0, lv: 1, x: 0, y: 0, z: 0, nx: 0, ny: 0, nz: 32767, id: 16'd7};
    send_vertex(w);
    // open polygon abandoned by a new first vertex
    send_polygon(0, 1, 50 <<< 16, 0, 0, 0, 0, 0, 32767, 16'd8, 0);
    w = '{sq: 0, fv: 0, lv: 0, x: 60 <<< 16, y: 0, z: 0, nx: 0, ny: 0, nz: 0, id: 16'd8};
    send_vertex(w);
    send_polygon(0, 4, 0, 0, 1 <<< 16, 4 <<< 16, 0, 0, 32767, 16'd9, 0);
    // off-center miss and back-facing miss
    send_polygon(0, 4, 40 <<< 16, 0, 0, 3 <<< 16, 0, 0, 32767, 16'd10, 0);
    send_polygon(0, 4, 0, 0, 0, 3 <<< 16, 0, 0, -32768, 16'd11, 0);
    drain();
  endtask

  task automatic test_field_extremes;
    vertex_t w;
    set_segment(-64'sh8000_0000, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                64'sh7FFF_FFFF, -64'sh8000_0000, -64'sh8000_0000, 0);
    w = '{sq: 1, fv: 1, lv: 0, x: 32'sh7FFF_FFFF, y: 32'sh7FFF_FFFF, z: 0,
          nx: -16'sd32768, ny: 16'sd32767, nz: 16'sd32767, id: 16'hFFFF};
    send_vertex(w);
    w = '{sq: 0, fv: 0, lv: 0, x: -32'sh8000_0000, y: 32'sh7FFF_FFFF, z: -32'sh8000_0000,
          nx: 16'sd32767, ny: -16'sd32768, nz: -16'sd32768, id: 16'h0000};
    send_vertex(w);
    w = '{sq: 0, fv: 0, lv: 1, x: -32'sh8000_0000, y: -32'sh8000_0000, z: 32'sh7FFF_FFFF,
          nx: 0, ny: 0, nz: 0, id: 16'hFFFF};
    send_vertex(w);
    w = '{sq: 0, fv: 1, lv: 1, x: 0, y: 0, z: 0, nx: 16'sd32767, ny: -16'sd32768, nz: 0,
          id: 16'h0000};
    send_vertex(w);
    drain();
  endtask

  task automatic test_early_out;
    set_segment(1 <<< 16, -(1 <<< 16), 20 <<< 16, -(1 <<< 16), 1 <<< 16, -(20 <<< 16), 1);
    send_polygon(1, 4, 0, 0, 25 <<< 16, 3 <<< 16, 0, 0, 32767, 16'd20, 0);
    send_polygon(0, 4, 0, 0, 5 <<< 16, 3 <<< 16, 0, 0, 32767, 16'd21, 0);
    send_polygon(0, 4, 0, 0, -(5 <<< 16), 3 <<< 16, 0, 0, 32767, 16'd22, 0);
    send_polygon(0, 2, 0, 0, 0, 3 <<< 16, 0, 0, 32767, 16'd23, 0);
    send_polygon(1, 4, 0, 0, 0, 3 <<< 16, 0, 0, 32767, 16'd24, 0);
    drain();
  endtask

  task automatic test_random_queries(input int quota, input bit stop);
    longint za, zb;
    za = $urandom_range(1, 100) <<< 16;
    zb = $urandom_range(1, 100) <<< 16;
    set_segment($signed($urandom_range(0, 4 << 16)) - (2 <<< 16),
                $signed($urandom_range(0, 4 << 16)) - (2 <<< 16), za,
                $signed($urandom_range(0, 4 << 16)) - (2 <<< 16),
                $signed($urandom_range(0, 4 << 16)) - (2 <<< 16), -zb, stop);
    repeat (quota) begin
      if ($urandom_range(0, 9) == 0) begin
        send_vertex(noise_vertex());
      end else begin
        longint pz;
        pz = $signed($urandom_range(0, 2 * (za + zb))) - zb - (za + zb) / 2;
        send_polygon($urandom_range(0, 4) == 0, $urandom_range(1, 6),
                     $signed($urandom_range(0, 16 << 16)) - (8 <<< 16),
                     $signed($urandom_range(0, 16 << 16)) - (8 <<< 16), pz,
                     $urandom_range(1, 20) <<< 16,
                     16'($signed($urandom_range(0, 4000)) - 2000),
                     16'($signed($urandom_range(0, 4000)) - 2000),
                     ($urandom_range(0, 7) == 0) ? -16'sd32000 : 16'sd32767,
                     16'($urandom), $urandom_range(0, 3) == 0 ? (1 << 17) : 0);
      end
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    in_tvalid <= 1'b0; in_tdata <= '0; in_tuser <= '0; in_tlast <= 1'b0;
    mismatches = 0; burst_left = 0; idle_on = 1;
    stop_first = 0; cand = 0; held = 0; frozen = 0;
    cur_frac = '0; held_frac = '0; held_poly = '0;
    for (int k = 0; k < 6; k++) seg_pt[k] = 0;
    for (int k = 0; k < 3; k++) begin
      first_c[k] = 0; prev_c[k] = 0; xpt[k] = 0; fnorm[k] = 0; held_norm[k] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (40) @(posedge clk);

    test_basic_crossings();
    test_field_extremes();
    test_early_out();
    idle_on = 0;
    test_random_queries(120, 0);
    idle_on = 1;
    test_random_queries(225, 1);
    test_random_queries(225, 0);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 6000000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
